// ===== rtl/shallow_water_rusanov_flux_top_assert.svh =====
// ----------------------------------------------------------------------------
// shallow water rusanov flux assertion macros
// concurrent assertion shorthands used by the checker file swrf_check
// ----------------------------------------------------------------------------
`ifndef SHALLOW_WATER_RUSANOV_FLUX_TOP_ASSERT_SVH
`define SHALLOW_WATER_RUSANOV_FLUX_TOP_ASSERT_SVH

// antecedent implies consequent a fixed number of cycles later
`define SWRF_ASSERT_DELAY(label, clk, rst, ante, cons, n) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##(n) (cons)) \
      else $error("delayed property failed");

// antecedent implies consequent in the same cycle
`define SWRF_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("property failed");

`endif

// ===== rtl/swrf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swrf_pkg
// shared constants and the pipeline side-band type of the rusanov flux block
// ----------------------------------------------------------------------------
package swrf_pkg;

   localparam int FRAC_BITS_DEFAULT = 16;
   localparam int DATA_W            = 32;
   localparam int WORK_W            = 64;
   localparam int MUL_LATENCY       = 7;
   localparam int SQRT_STEPS        = 32;
   localparam int SQRT_LATENCY      = SQRT_STEPS + 1;
   localparam int LATENCY           = 1 + 4 * MUL_LATENCY + SQRT_LATENCY + 2;

   typedef struct packed {
      logic                     dry;
      logic signed [WORK_W-1:0] hl;
      logic signed [WORK_W-1:0] hr;
      logic signed [WORK_W-1:0] ul;
      logic signed [WORK_W-1:0] ur;
      logic signed [WORK_W-1:0] vl;
      logic signed [WORK_W-1:0] vr;
      logic signed [WORK_W-1:0] aul;
      logic signed [WORK_W-1:0] aur;
      logic signed [WORK_W-1:0] ql;
      logic signed [WORK_W-1:0] qr;
      logic signed [WORK_W-1:0] g2l;
      logic signed [WORK_W-1:0] g2r;
      logic signed [WORK_W-1:0] hvl;
      logic signed [WORK_W-1:0] hvr;
      logic signed [WORK_W-1:0] cl;
      logic signed [WORK_W-1:0] cr;
      logic signed [WORK_W-1:0] pl;
      logic signed [WORK_W-1:0] pr;
      logic signed [WORK_W-1:0] avg1;
      logic signed [WORK_W-1:0] avg3;
      logic signed [WORK_W-1:0] dh;
      logic signed [WORK_W-1:0] dq;
      logic signed [WORK_W-1:0] dhv;
   } work_type;

endpackage

// ===== rtl/swrf_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swrf_mul
// pipelined fixed point multiplier lanes, rounded half away from zero and
// saturated to 64 bits, with a side-band record carried alongside
// ----------------------------------------------------------------------------
module swrf_mul #(
   parameter int FRAC_BITS = swrf_pkg::FRAC_BITS_DEFAULT,
   parameter int LANES     = 1
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   input  logic signed [swrf_pkg::WORK_W-1:0]  op_a [LANES],
   input  logic signed [swrf_pkg::WORK_W-1:0]  op_b [LANES],
   input  swrf_pkg::work_type                  in_side,
   output logic                                out_valid,
   output logic signed [swrf_pkg::WORK_W-1:0]  res [LANES],
   output swrf_pkg::work_type                  out_side
);

   localparam int           LAT     = swrf_pkg::MUL_LATENCY;
   localparam logic [127:0] RND     = 128'(1) << (FRAC_BITS - 1);
   localparam logic [63:0]  POS_MAX = {1'b0, {63{1'b1}}};
   localparam logic [63:0]  NEG_MIN = {1'b1, {63{1'b0}}};

   logic               valid_ff [LAT];
   swrf_pkg::work_type side_ff  [LAT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LAT; i++) valid_ff[i] <= 1'b0;
      end else begin
         valid_ff[0] <= in_valid;
         for (int i = 1; i < LAT; i++) valid_ff[i] <= valid_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      side_ff[0] <= in_side;
      for (int i = 1; i < LAT; i++) side_ff[i] <= side_ff[i-1];
   end

   assign out_valid = valid_ff[LAT-1];
   assign out_side  = side_ff[LAT-1];

   for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic signed [63:0] a_ff, b_ff;
      logic               neg2_ff, neg3_ff, neg4_ff, neg5_ff, neg6_ff;
      logic [63:0]        ua_ff, ub_ff;
      logic [63:0]        p00_ff, p01_ff, p10_ff, p11_ff;
      logic [33:0]        mid_ff;
      logic [31:0]        lo_ff;
      logic [63:0]        hs_ff;
      logic [127:0]       prod_ff, rnd_ff;
      logic [63:0]        res_ff;
      logic               ovf;
      logic [63:0]        mag_v;
      logic [63:0]        res_in;

      always_comb begin
         ovf   = |rnd_ff[127:64+FRAC_BITS];
         mag_v = rnd_ff[63+FRAC_BITS:FRAC_BITS];
         if (ovf) begin
            res_in = neg6_ff ? NEG_MIN : POS_MAX;
         end else if (neg6_ff) begin
            res_in = mag_v[63] ? NEG_MIN : (64'd0 - mag_v);
         end else begin
            res_in = mag_v[63] ? POS_MAX : mag_v;
         end
      end

      always_ff @(posedge clock) begin
         a_ff    <= op_a[l];
         b_ff    <= op_b[l];
         neg2_ff <= a_ff[63] ^ b_ff[63];
         ua_ff   <= a_ff[63] ? (64'd0 - 64'(a_ff)) : 64'(a_ff);
         ub_ff   <= b_ff[63] ? (64'd0 - 64'(b_ff)) : 64'(b_ff);
         neg3_ff <= neg2_ff;
         p00_ff  <= {32'd0, ua_ff[31:0]}  * {32'd0, ub_ff[31:0]};
         p01_ff  <= {32'd0, ua_ff[31:0]}  * {32'd0, ub_ff[63:32]};
         p10_ff  <= {32'd0, ua_ff[63:32]} * {32'd0, ub_ff[31:0]};
         p11_ff  <= {32'd0, ua_ff[63:32]} * {32'd0, ub_ff[63:32]};
         neg4_ff <= neg3_ff;
         mid_ff  <= 34'(p00_ff[63:32]) + 34'(p01_ff[31:0]) + 34'(p10_ff[31:0]);
         hs_ff   <= p11_ff + 64'(p01_ff[63:32]) + 64'(p10_ff[63:32]);
         lo_ff   <= p00_ff[31:0];
         neg5_ff <= neg4_ff;
         prod_ff <= {hs_ff + 64'(mid_ff[33:32]), mid_ff[31:0], lo_ff};
         neg6_ff <= neg5_ff;
         rnd_ff  <= prod_ff + RND;
         res_ff  <= res_in;
      end

      assign res[l] = res_ff;
   end

endmodule

// ===== rtl/swrf_sqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swrf_sqrt
// pipelined integer square root, one result bit per stage, with a
// side-band record carried alongside
// ----------------------------------------------------------------------------
module swrf_sqrt #(
   parameter int LANES = 1
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   input  logic [swrf_pkg::WORK_W-1:0]        arg [LANES],
   input  swrf_pkg::work_type                 in_side,
   output logic                               out_valid,
   output logic [swrf_pkg::DATA_W-1:0]        root [LANES],
   output swrf_pkg::work_type                 out_side
);

   localparam int STEPS = swrf_pkg::SQRT_STEPS;
   localparam int LAT   = swrf_pkg::SQRT_LATENCY;

   logic               valid_ff [LAT];
   swrf_pkg::work_type side_ff  [LAT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LAT; i++) valid_ff[i] <= 1'b0;
      end else begin
         valid_ff[0] <= in_valid;
         for (int i = 1; i < LAT; i++) valid_ff[i] <= valid_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      side_ff[0] <= in_side;
      for (int i = 1; i < LAT; i++) side_ff[i] <= side_ff[i-1];
   end

   assign out_valid = valid_ff[LAT-1];
   assign out_side  = side_ff[LAT-1];

   for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [63:0] x_ff [STEPS+1];
      logic [63:0] r_ff [STEPS+1];
      logic [63:0] t_w  [STEPS];

      always_comb begin
         for (int k = 0; k < STEPS; k++) begin
            t_w[k] = r_ff[k] + (64'd1 << (62 - 2 * k));
         end
      end

      always_ff @(posedge clock) begin
         x_ff[0] <= arg[l];
         r_ff[0] <= 64'd0;
         for (int k = 0; k < STEPS; k++) begin
            if (x_ff[k] >= t_w[k]) begin
               x_ff[k+1] <= x_ff[k] - t_w[k];
               r_ff[k+1] <= (r_ff[k] >> 1) + (64'd1 << (62 - 2 * k));
            end else begin
               x_ff[k+1] <= x_ff[k];
               r_ff[k+1] <= r_ff[k] >> 1;
            end
         end
      end

      assign root[l] = r_ff[STEPS][31:0];
   end

endmodule

// ===== rtl/shallow_water_rusanov_flux_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shallow_water_rusanov_flux_top
// rusanov flux of the 2d shallow water equations for one cell interface
// ----------------------------------------------------------------------------
// a request is taken at a rising edge with start high and busy low; it
// carries both depths and the normal and tangential velocities of each side
// in signed fixed point. one result per request comes out on the rsp_ ports
// for a single cycle, marked by rsp_strobe, once it has passed the multiplier
// banks, square root and output registers; results leave in request order.
// the pipeline takes a new request every cycle, so busy is low at all times
// except while reset is held and the cycle after it.
// the latency is set by the chain of four seven-stage multiplier banks and
// the 33-stage square root (an input register, then one result bit per stage).
// reset is synchronous and clears every valid bit in flight; requests in the
// pipeline at reset are dropped.
// the receiver cannot hold results off, so nothing ever stalls.
// a dry interface (both depths at or below zero) returns three zero fluxes.
// ----------------------------------------------------------------------------
module shallow_water_rusanov_flux_top #(
   parameter int FRAC_BITS = swrf_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic signed [swrf_pkg::DATA_W-1:0]  req_depth_left,
   input  logic signed [swrf_pkg::DATA_W-1:0]  req_depth_right,
   input  logic signed [swrf_pkg::DATA_W-1:0]  req_normal_vel_left,
   input  logic signed [swrf_pkg::DATA_W-1:0]  req_normal_vel_right,
   input  logic signed [swrf_pkg::DATA_W-1:0]  req_tangent_vel_left,
   input  logic signed [swrf_pkg::DATA_W-1:0]  req_tangent_vel_right,
   output logic                                rsp_strobe,
   output logic signed [swrf_pkg::DATA_W-1:0]  rsp_mass_flux,
   output logic signed [swrf_pkg::DATA_W-1:0]  rsp_normal_momentum_flux,
   output logic signed [swrf_pkg::DATA_W-1:0]  rsp_tangent_momentum_flux
);

   localparam int W  = swrf_pkg::WORK_W;
   localparam int DW = swrf_pkg::DATA_W;
   localparam logic signed [W-1:0] G_RAW  =
      W'(((64'd981 << FRAC_BITS) + 64'd50) / 64'd100);
   localparam logic signed [W-1:0] G_HALF =
      W'(((64'd4905 << FRAC_BITS) + 64'd500) / 64'd1000);
   localparam logic signed [W-1:0] HALF    = W'(64'd1 << (FRAC_BITS - 1));
   localparam logic signed [W-1:0] POS_MAX = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] NEG_MIN = {1'b1, {(W-1){1'b0}}};
   localparam logic signed [W-1:0] OUT_MAX = {{(W-DW+1){1'b0}}, {(DW-1){1'b1}}};
   localparam logic signed [W-1:0] OUT_MIN = {{(W-DW+1){1'b1}}, {(DW-1){1'b0}}};
   localparam int L1 = 8;
   localparam int L2 = 2;
   localparam int L3 = 7;
   localparam int L4 = 2;
   localparam int L5 = 4;

   function automatic logic signed [W-1:0] sat_add(input logic signed [W-1:0] a,
                                                   input logic signed [W-1:0] b);
      logic [W:0] s;
      s = {a[W-1], a} + {b[W-1], b};
      if (s[W] != s[W-1]) return s[W] ? NEG_MIN : POS_MAX;
      return s[W-1:0];
   endfunction

   function automatic logic signed [W-1:0] sat_sub(input logic signed [W-1:0] a,
                                                   input logic signed [W-1:0] b);
      logic [W:0] s;
      s = {a[W-1], a} - {b[W-1], b};
      if (s[W] != s[W-1]) return s[W] ? NEG_MIN : POS_MAX;
      return s[W-1:0];
   endfunction

   function automatic logic signed [W-1:0] sext(input logic signed [DW-1:0] x);
      return {{(W-DW){x[DW-1]}}, x};
   endfunction

   function automatic logic signed [W-1:0] abs_w(input logic signed [W-1:0] x);
      return x[W-1] ? (W'(0) - x) : x;
   endfunction

   // request capture
   logic                 busy_ff;
   logic                 req_valid_ff;
   logic signed [DW-1:0] hl_ff, hr_ff, ul_ff, ur_ff, vl_ff, vr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b1;
         req_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= 1'b0;
         req_valid_ff <= start && !busy_ff;
      end
   end

   always_ff @(posedge clock) begin
      hl_ff <= req_depth_left;
      hr_ff <= req_depth_right;
      ul_ff <= req_normal_vel_left;
      ur_ff <= req_normal_vel_right;
      vl_ff <= req_tangent_vel_left;
      vr_ff <= req_tangent_vel_right;
   end

   assign busy = busy_ff;

   // first products
   logic signed [W-1:0] m1_a [L1], m1_b [L1], m1_res [L1];
   swrf_pkg::work_type  m1_in_side, m1_side;
   logic                m1_valid;

   always_comb begin
      logic signed [W-1:0] hl, hr;
      hl = sext(hl_ff);
      hr = sext(hr_ff);
      m1_in_side      = '0;
      m1_in_side.dry  = (hl <= 0) && (hr <= 0);
      m1_in_side.hl   = hl;
      m1_in_side.hr   = hr;
      m1_in_side.ul   = sext(ul_ff);
      m1_in_side.ur   = sext(ur_ff);
      m1_in_side.vl   = sext(vl_ff);
      m1_in_side.vr   = sext(vr_ff);
      m1_in_side.aul  = abs_w(sext(ul_ff));
      m1_in_side.aur  = abs_w(sext(ur_ff));
      m1_a[0] = G_RAW;  m1_b[0] = (hl > 0) ? hl : '0;
      m1_a[1] = G_RAW;  m1_b[1] = (hr > 0) ? hr : '0;
      m1_a[2] = m1_in_side.ul; m1_b[2] = hl;
      m1_a[3] = m1_in_side.ur; m1_b[3] = hr;
      m1_a[4] = G_HALF; m1_b[4] = hl;
      m1_a[5] = G_HALF; m1_b[5] = hr;
      m1_a[6] = hl;     m1_b[6] = m1_in_side.vl;
      m1_a[7] = hr;     m1_b[7] = m1_in_side.vr;
   end

   swrf_mul #(.FRAC_BITS(FRAC_BITS), .LANES(L1)) u_mul1 (
      .clock(clock), .reset(reset), .in_valid(req_valid_ff),
      .op_a(m1_a), .op_b(m1_b), .in_side(m1_in_side),
      .out_valid(m1_valid), .res(m1_res), .out_side(m1_side)
   );

   // wave speed roots
   logic [W-1:0]       sq_arg [L2];
   logic [DW-1:0]      sq_root [L2];
   swrf_pkg::work_type sq_in_side, sq_side;
   logic               sq_valid;

   always_comb begin
      sq_in_side     = m1_side;
      sq_in_side.ql  = m1_res[2];
      sq_in_side.qr  = m1_res[3];
      sq_in_side.g2l = m1_res[4];
      sq_in_side.g2r = m1_res[5];
      sq_in_side.hvl = m1_res[6];
      sq_in_side.hvr = m1_res[7];
      for (int i = 0; i < L2; i++) begin
         if (|m1_res[i][W-1:W-1-FRAC_BITS]) begin
            sq_arg[i] = POS_MAX;
         end else begin
            sq_arg[i] = {m1_res[i][W-1-FRAC_BITS:0], {FRAC_BITS{1'b0}}};
         end
      end
   end

   swrf_sqrt #(.LANES(L2)) u_sqrt (
      .clock(clock), .reset(reset), .in_valid(m1_valid),
      .arg(sq_arg), .in_side(sq_in_side),
      .out_valid(sq_valid), .root(sq_root), .out_side(sq_side)
   );

   // momentum products
   logic signed [W-1:0] m3_a [L3], m3_b [L3], m3_res [L3];
   swrf_pkg::work_type  m3_in_side, m3_side;
   logic                m3_valid;

   always_comb begin
      m3_in_side    = sq_side;
      m3_in_side.cl = sq_side.aul + W'(sq_root[0]);
      m3_in_side.cr = sq_side.aur + W'(sq_root[1]);
      m3_a[0] = sq_side.ul;  m3_b[0] = sq_side.ql;
      m3_a[1] = sq_side.ur;  m3_b[1] = sq_side.qr;
      m3_a[2] = sq_side.g2l; m3_b[2] = sq_side.hl;
      m3_a[3] = sq_side.g2r; m3_b[3] = sq_side.hr;
      m3_a[4] = sq_side.ql;  m3_b[4] = sq_side.vl;
      m3_a[5] = sq_side.qr;  m3_b[5] = sq_side.vr;
      m3_a[6] = sat_add(sq_side.ql, sq_side.qr); m3_b[6] = HALF;
   end

   swrf_mul #(.FRAC_BITS(FRAC_BITS), .LANES(L3)) u_mul3 (
      .clock(clock), .reset(reset), .in_valid(sq_valid),
      .op_a(m3_a), .op_b(m3_b), .in_side(m3_in_side),
      .out_valid(m3_valid), .res(m3_res), .out_side(m3_side)
   );

   // speed halving and tangential average
   logic signed [W-1:0] m4_a [L4], m4_b [L4], m4_res [L4];
   swrf_pkg::work_type  m4_in_side, m4_side;
   logic                m4_valid;

   always_comb begin
      m4_in_side      = m3_side;
      m4_in_side.pl   = sat_add(m3_res[0], m3_res[2]);
      m4_in_side.pr   = sat_add(m3_res[1], m3_res[3]);
      m4_in_side.avg1 = m3_res[6];
      m4_in_side.dh   = sat_sub(m3_side.hr, m3_side.hl);
      m4_in_side.dq   = sat_sub(m3_side.qr, m3_side.ql);
      m4_in_side.dhv  = sat_sub(m3_side.hvr, m3_side.hvl);
      m4_a[0] = (m3_side.cl >= m3_side.cr) ? m3_side.cl : m3_side.cr;
      m4_b[0] = HALF;
      m4_a[1] = sat_add(m3_res[4], m3_res[5]);
      m4_b[1] = HALF;
   end

   swrf_mul #(.FRAC_BITS(FRAC_BITS), .LANES(L4)) u_mul4 (
      .clock(clock), .reset(reset), .in_valid(m3_valid),
      .op_a(m4_a), .op_b(m4_b), .in_side(m4_in_side),
      .out_valid(m4_valid), .res(m4_res), .out_side(m4_side)
   );

   // dissipation terms and normal momentum average
   logic signed [W-1:0] m5_a [L5], m5_b [L5], m5_res [L5];
   swrf_pkg::work_type  m5_in_side, m5_side;
   logic                m5_valid;

   always_comb begin
      m5_in_side      = m4_side;
      m5_in_side.avg3 = m4_res[1];
      m5_a[0] = m4_res[0]; m5_b[0] = m4_side.dh;
      m5_a[1] = m4_res[0]; m5_b[1] = m4_side.dq;
      m5_a[2] = m4_res[0]; m5_b[2] = m4_side.dhv;
      m5_a[3] = sat_add(m4_side.pl, m4_side.pr); m5_b[3] = HALF;
   end

   swrf_mul #(.FRAC_BITS(FRAC_BITS), .LANES(L5)) u_mul5 (
      .clock(clock), .reset(reset), .in_valid(m4_valid),
      .op_a(m5_a), .op_b(m5_b), .in_side(m5_in_side),
      .out_valid(m5_valid), .res(m5_res), .out_side(m5_side)
   );

   // flux differences
   logic                f_valid_ff;
   logic                f_dry_ff;
   logic signed [W-1:0] f1_ff, f2_ff, f3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else begin
         f_valid_ff <= m5_valid;
      end
   end

   always_ff @(posedge clock) begin
      f_dry_ff <= m5_side.dry;
      f1_ff    <= sat_sub(m5_side.avg1, m5_res[0]);
      f2_ff    <= sat_sub(m5_res[3], m5_res[1]);
      f3_ff    <= sat_sub(m5_side.avg3, m5_res[2]);
   end

   // output clamp
   function automatic logic signed [DW-1:0] clamp32(input logic signed [W-1:0] v);
      if (v > OUT_MAX) return OUT_MAX[DW-1:0];
      if (v < OUT_MIN) return OUT_MIN[DW-1:0];
      return v[DW-1:0];
   endfunction

   logic                 rsp_strobe_ff;
   logic signed [DW-1:0] rsp_mass_ff, rsp_normal_ff, rsp_tangent_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= f_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_mass_ff    <= f_dry_ff ? '0 : clamp32(f1_ff);
      rsp_normal_ff  <= f_dry_ff ? '0 : clamp32(f2_ff);
      rsp_tangent_ff <= f_dry_ff ? '0 : clamp32(f3_ff);
   end

   assign rsp_strobe                = rsp_strobe_ff;
   assign rsp_mass_flux             = rsp_mass_ff;
   assign rsp_normal_momentum_flux  = rsp_normal_ff;
   assign rsp_tangent_momentum_flux = rsp_tangent_ff;

endmodule

// ===== rtl/swrf_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swrf_check
// port level checks of the rusanov flux block, bound to the top level
// ----------------------------------------------------------------------------
`include "shallow_water_rusanov_flux_top_assert.svh"

module swrf_check #(
   parameter int LATENCY = swrf_pkg::LATENCY
) (
   input logic                                clock,
   input logic                                reset,
   input logic                                start,
   input logic                                busy,
   input logic signed [swrf_pkg::DATA_W-1:0]  req_depth_left,
   input logic signed [swrf_pkg::DATA_W-1:0]  req_depth_right,
   input logic signed [swrf_pkg::DATA_W-1:0]  req_normal_vel_left,
   input logic signed [swrf_pkg::DATA_W-1:0]  req_normal_vel_right,
   input logic signed [swrf_pkg::DATA_W-1:0]  req_tangent_vel_left,
   input logic signed [swrf_pkg::DATA_W-1:0]  req_tangent_vel_right,
   input logic                                rsp_strobe,
   input logic signed [swrf_pkg::DATA_W-1:0]  rsp_mass_flux,
   input logic signed [swrf_pkg::DATA_W-1:0]  rsp_normal_momentum_flux,
   input logic signed [swrf_pkg::DATA_W-1:0]  rsp_tangent_momentum_flux
);

   logic req_take, req_dry, rsp_zero;

   assign req_take = start && !busy;
   assign req_dry  = req_take && (req_depth_left <= 0) && (req_depth_right <= 0);
   assign rsp_zero = (rsp_mass_flux == 0) && (rsp_normal_momentum_flux == 0) &&
                     (rsp_tangent_momentum_flux == 0);

   // every request gives a result after the fixed latency
   `SWRF_ASSERT_DELAY(a_latency, clock, reset, req_take, rsp_strobe, LATENCY)

   // no result without a request
   `SWRF_ASSERT_IMPL(a_no_spurious, clock, reset, rsp_strobe, $past(req_take, LATENCY))

   // dry interface gives zero fluxes
   `SWRF_ASSERT_DELAY(a_dry, clock, reset, req_dry, rsp_zero, LATENCY)

   // busy only around reset
   `SWRF_ASSERT_IMPL(a_busy, clock, reset, !$past(reset), !busy)

endmodule

bind shallow_water_rusanov_flux_top swrf_check u_swrf_check (.*);
